// ===== rtl/dss_pkg.sv =====
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types, sizes and helpers for the discrete state-space step unit.
// ----------------------------------------------------------------------------
package dss_pkg;

	localparam int N_STATES  = 4;
	localparam int N_INPUTS  = 2;
	localparam int N_OUTPUTS = 2;

	localparam int STATE_PORTS = 4;
	localparam int OUT_PORTS   = 2;

	localparam int A_BASE     = 0;
	localparam int B_BASE     = N_STATES * N_STATES;
	localparam int C_BASE     = B_BASE + N_STATES * N_INPUTS;
	localparam int COEF_DEPTH = C_BASE + N_OUTPUTS * N_STATES;
	localparam int COEF_AW    = $clog2(COEF_DEPTH);

	localparam int COEF_W = 16;
	localparam int SIG_W  = 24;
	localparam int FRAC_C = 14;

	localparam int ROW_TERMS = N_STATES + N_INPUTS;
	localparam int ROW_N     = (N_STATES > N_OUTPUTS) ? N_STATES : N_OUTPUTS;
	localparam int ROW_W     = (ROW_N > 1) ? $clog2(ROW_N) : 1;
	localparam int COL_W     = $clog2(ROW_TERMS);
	localparam int XW        = (N_STATES > 1) ? $clog2(N_STATES) : 1;

	localparam int PROD_W = COEF_W + SIG_W;
	localparam int ACC_W  = PROD_W + $clog2(ROW_TERMS) + 1;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [SIG_W-1:0]  sig_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic [COEF_AW-1:0]       coef_addr_t;
	typedef logic [ROW_W-1:0]         row_t;
	typedef logic [COL_W-1:0]         col_t;

	typedef enum logic [1:0] {
		OP_COEF  = 2'd0,
		OP_STATE = 2'd1,
		OP_STEP  = 2'd2
	} opcode_t;

	typedef struct packed {
		logic first;
		logic last;
		logic dst_out;
		row_t row;
	} mac_tag_t;

	typedef struct packed {
		logic     valid;
		logic     sat;
		sig_t     value;
		mac_tag_t tag;
	} mac_res_t;

	localparam acc_t ACC_RND     = acc_t'(1 << (FRAC_C - 1));
	localparam acc_t ACC_SIG_MAX = acc_t'(2 ** (SIG_W - 1) - 1);
	localparam acc_t ACC_SIG_MIN = acc_t'(-(2 ** (SIG_W - 1)));
	localparam sig_t SIG_MAX     = sig_t'(2 ** (SIG_W - 1) - 1);
	localparam sig_t SIG_MIN     = sig_t'(-(2 ** (SIG_W - 1)));
	localparam sig_t COEF_MAX_S  = sig_t'(2 ** (COEF_W - 1) - 1);
	localparam sig_t COEF_MIN_S  = sig_t'(-(2 ** (COEF_W - 1)));

	function automatic coef_t sat_coef(input sig_t v);
		coef_t r;
		if (v > COEF_MAX_S) begin
			r = coef_t'(COEF_MAX_S);
		end else if (v < COEF_MIN_S) begin
			r = coef_t'(COEF_MIN_S);
		end else begin
			r = v[COEF_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/dss_coef_store.sv =====
// ----------------------------------------------------------------------------
// dss_coef_store
// Coefficient store for A, B and C with one write port and a registered read.
// ----------------------------------------------------------------------------
module dss_coef_store import dss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  coef_addr_t wr_addr,
	input  coef_t      wr_data,
	input  coef_addr_t rd_addr,
	output coef_t      rd_data
);

	coef_t mem_q [COEF_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COEF_DEPTH; i++) begin
				mem_q[i] <= '0;
			end
			rd_data <= '0;
		end else begin
			if (wr_en) begin
				mem_q[wr_addr] <= wr_data;
			end
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/dss_mac.sv =====
// ----------------------------------------------------------------------------
// dss_mac
// Shared multiply-accumulate with round half up and saturation to Q12.12.
// ----------------------------------------------------------------------------
module dss_mac import dss_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  coef_t    coef,
	input  sig_t     operand,
	input  mac_tag_t in_tag,
	output mac_res_t res
);

	prod_t    prod_s2;
	mac_tag_t tag_s2;
	mac_tag_t tag_s3;
	logic     valid_s2;
	logic     valid_s3;
	acc_t     acc_q;
	acc_t     shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod_t'(coef) * prod_t'(operand);
		tag_s2  <= in_tag;
		tag_s3  <= tag_s2;
		if (valid_s2) begin
			acc_q <= (tag_s2.first ? ACC_RND : acc_q) + acc_t'(prod_s2);
		end
	end

	always_comb begin
		shifted   = acc_q >>> FRAC_C;
		res.valid = valid_s3 & tag_s3.last;
		res.tag   = tag_s3;
		if (shifted > ACC_SIG_MAX) begin
			res.sat   = 1'b1;
			res.value = SIG_MAX;
		end else if (shifted < ACC_SIG_MIN) begin
			res.sat   = 1'b1;
			res.value = SIG_MIN;
		end else begin
			res.sat   = 1'b0;
			res.value = shifted[SIG_W-1:0];
		end
	end

endmodule

// ===== rtl/discrete_state_space_step_unit.sv =====
// ----------------------------------------------------------------------------
// discrete_state_space_step_unit
// Discrete-time state-space system: y = C*x, then x = A*x + B*u per step,
// all products on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//  channel   signals                                   transfer when
//  input     in_valid/in_ready, opcode..input_b        in_valid & in_ready
//  output    out_valid/out_ready, out_a..saturated     out_valid & out_ready
//
//  load items finish on transfer, leaving the input ready; a step runs the
//  C rows, then the A and B rows, then drains the accumulator pipeline,
//  one product per cycle through the shared multiply-accumulate
//  reset clears the coefficient store, the state vector and all control
//  a finished step waits in its last state while the output register is full
// ----------------------------------------------------------------------------
module discrete_state_space_step_unit import dss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	input  logic [4:0] index,
	input  sig_t       value,
	input  sig_t       input_a,
	input  sig_t       input_b,
	output logic       out_valid,
	input  logic       out_ready,
	output sig_t       out_a,
	output sig_t       out_b,
	output sig_t       state_e0,
	output sig_t       state_e1,
	output sig_t       state_e2,
	output sig_t       state_e3,
	output logic       saturated
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_OUT,
		S_UPD,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t     state_q;
	row_t       row_q;
	col_t       col_q;
	logic       sat_q;
	logic       out_valid_q;
	sig_t       out_y_q [OUT_PORTS];
	sig_t       out_x_q [STATE_PORTS];
	logic       out_sat_q;
	sig_t       x_q [N_STATES];
	sig_t       xn_q [N_STATES];
	sig_t       y_q [OUT_PORTS];
	sig_t       u_q [2];
	sig_t       x_pad [STATE_PORTS];
	sig_t       y_pad [OUT_PORTS];

	logic       valid_s1;
	sig_t       operand_s1;
	mac_tag_t   tag_s1;

	logic       accept;
	logic       issue_valid;
	logic       col_last;
	logic       row_last;
	logic       col_is_x;
	col_t       u_sel;
	coef_addr_t rd_addr;
	sig_t       operand;
	mac_tag_t   tag;
	coef_t      coef_rd;
	logic       coef_wr_en;
	mac_res_t   mac_res;
	logic       final_wb;

	assign in_ready   = (state_q == S_IDLE);
	assign accept     = in_valid & in_ready;
	assign coef_wr_en = accept && (opcode == OP_COEF) && (32'(index) < COEF_DEPTH);

	always_comb begin
		issue_valid = (state_q == S_OUT) || (state_q == S_UPD);
		if (state_q == S_OUT) begin
			col_last = (col_q == col_t'(N_STATES - 1));
			row_last = (row_q == row_t'(N_OUTPUTS - 1));
		end else begin
			col_last = (col_q == col_t'(ROW_TERMS - 1));
			row_last = (row_q == row_t'(N_STATES - 1));
		end
		col_is_x = (32'(col_q) < N_STATES);
		u_sel    = col_q - col_t'(N_STATES);
		if (state_q == S_OUT) begin
			rd_addr = coef_addr_t'(C_BASE + 32'(row_q) * N_STATES + 32'(col_q));
		end else if (col_is_x) begin
			rd_addr = coef_addr_t'(A_BASE + 32'(row_q) * N_STATES + 32'(col_q));
		end else begin
			rd_addr = coef_addr_t'(B_BASE + 32'(row_q) * N_INPUTS + 32'(u_sel));
		end
		operand     = col_is_x ? x_q[col_q[XW-1:0]] : u_q[u_sel[0]];
		tag.first   = (col_q == '0);
		tag.last    = col_last;
		tag.dst_out = (state_q == S_OUT);
		tag.row     = row_q;
	end

	always_comb begin
		for (int i = 0; i < STATE_PORTS; i++) begin
			x_pad[i] = '0;
		end
		for (int i = 0; i < N_STATES && i < STATE_PORTS; i++) begin
			x_pad[i] = x_q[i];
		end
		for (int i = 0; i < OUT_PORTS; i++) begin
			y_pad[i] = (i < N_OUTPUTS) ? y_q[i] : '0;
		end
	end

	assign final_wb = mac_res.valid && !mac_res.tag.dst_out &&
		(mac_res.tag.row == row_t'(N_STATES - 1));

	dss_coef_store u_coef_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (coef_wr_en),
		.wr_addr (coef_addr_t'(index)),
		.wr_data (sat_coef(value)),
		.rd_addr (rd_addr),
		.rd_data (coef_rd)
	);

	dss_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.coef     (coef_rd),
		.operand  (operand_s1),
		.in_tag   (tag_s1),
		.res      (mac_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			sat_q       <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			out_sat_q   <= 1'b0;
			for (int i = 0; i < OUT_PORTS; i++) begin
				out_y_q[i] <= '0;
			end
			for (int i = 0; i < STATE_PORTS; i++) begin
				out_x_q[i] <= '0;
			end
			for (int i = 0; i < N_STATES; i++) begin
				x_q[i] <= '0;
			end
		end else begin
			valid_s1 <= issue_valid;
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			if (mac_res.valid) begin
				sat_q <= sat_q | mac_res.sat;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (opcode)
							OP_STATE: begin
								if (32'(index) < N_STATES) begin
									x_q[index[XW-1:0]] <= value;
								end
							end
							OP_STEP: begin
								state_q <= S_OUT;
								row_q   <= '0;
								col_q   <= '0;
								sat_q   <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				S_OUT, S_UPD: begin
					if (col_last) begin
						col_q <= '0;
						if (row_last) begin
							row_q   <= '0;
							state_q <= (state_q == S_OUT) ? S_UPD : S_DRAIN;
						end else begin
							row_q <= row_q + row_t'(1);
						end
					end else begin
						col_q <= col_q + col_t'(1);
					end
				end
				S_DRAIN: begin
					if (final_wb) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_sat_q   <= sat_q;
						out_y_q     <= y_pad;
						out_x_q     <= x_pad;
						x_q         <= xn_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		operand_s1 <= operand;
		tag_s1     <= tag;
		if (accept && (opcode == OP_STEP)) begin
			u_q[0] <= input_a;
			u_q[1] <= input_b;
		end
		if (mac_res.valid) begin
			if (mac_res.tag.dst_out) begin
				y_q[mac_res.tag.row[0]] <= mac_res.value;
			end else begin
				xn_q[mac_res.tag.row[XW-1:0]] <= mac_res.value;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_a     = out_y_q[0];
	assign out_b     = out_y_q[1];
	assign state_e0  = out_x_q[0];
	assign state_e1  = out_x_q[1];
	assign state_e2  = out_x_q[2];
	assign state_e3  = out_x_q[3];
	assign saturated = out_sat_q;

`ifndef NO_ASSERTIONS
	a_idle_no_mac: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !mac_res.valid)
		else $error("accumulator result while idle");

	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (opcode == OP_STEP)) |=> !in_ready)
		else $error("step transfer did not start the sequencer");

	a_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && (!out_valid_q || out_ready)) |=> (out_valid && in_ready))
		else $error("finished step did not reach the output register");

	a_out_row: assert property (@(posedge clk) disable iff (!arst_n)
		(mac_res.valid && mac_res.tag.dst_out) |-> (32'(mac_res.tag.row) < N_OUTPUTS))
		else $error("output row out of range");
`endif

endmodule

// ===== sim/discrete_state_space_step_unit_tb.sv =====
// ----------------------------------------------------------------------------
// discrete_state_space_step_unit_tb
// Self-checking bench for the state-space step unit. Coefficient and state
// loads plus steps are queued and driven over valid/ready with random gaps.
// Every step's y = C*x, x and saturation flag are predicted from a shadow
// coefficient store and state vector, then compared in order with each
// result transfer taken under random back-pressure.
// ----------------------------------------------------------------------------
module discrete_state_space_step_unit_tb;
	import dss_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int COEF_TOP     = 32767;
	localparam int COEF_BOTTOM  = -32768;
	localparam int ITEM_TARGET  = 600;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct {
		logic [1:0] op;
		logic [4:0] idx;
		sig_t       val;
		sig_t       ua;
		sig_t       ub;
	} cmd_t;

	typedef struct {
		sig_t ya;
		sig_t yb;
		sig_t x0;
		sig_t x1;
		sig_t x2;
		sig_t x3;
		logic sat;
	} step_out_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] opcode = '0;
	logic [4:0] index = '0;
	sig_t       value = '0;
	sig_t       input_a = '0;
	sig_t       input_b = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	sig_t       out_a;
	sig_t       out_b;
	sig_t       state_e0;
	sig_t       state_e1;
	sig_t       state_e2;
	sig_t       state_e3;
	logic       saturated;

	discrete_state_space_step_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.index     (index),
		.value     (value),
		.input_a   (input_a),
		.input_b   (input_b),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_a     (out_a),
		.out_b     (out_b),
		.state_e0  (state_e0),
		.state_e1  (state_e1),
		.state_e2  (state_e2),
		.state_e3  (state_e3),
		.saturated (saturated)
	);

	coef_t     coef_mirror[COEF_DEPTH];
	sig_t      state_mirror[N_STATES];
	cmd_t      pending[$];
	step_out_t step_results_due[$];
	cmd_t      cur_cmd;
	step_out_t new_result;
	step_out_t want;
	int        real_items = 0;
	int        errors = 0;
	int        results_seen = 0;
	int        cycles = 0;
	int        send_gap = 0;
	int        send_calm = 0;
	int        take_stall = 0;
	int        take_calm = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic sig_t round_clip(input longint sum, inout bit clipped);
		longint q;
		q = (sum + 64'sd8192) >>> 14;
		if (q > longint'(SIG_MAX)) begin
			clipped = 1'b1;
			return SIG_MAX;
		end
		if (q < longint'(SIG_MIN)) begin
			clipped = 1'b1;
			return SIG_MIN;
		end
		return sig_t'(q);
	endfunction

	// updates the shadow store; returns 1 when the item produces a result
	function automatic bit plant_apply(input cmd_t c, output step_out_t r);
		longint sum;
		sig_t   y[2];
		sig_t   u_vec[2];
		sig_t   x_next[N_STATES];
		bit     clipped;
		r = '{default: '0};
		clipped = 1'b0;
		y[0] = '0;
		y[1] = '0;
		if (c.op == OP_COEF) begin
			if (int'(c.idx) < COEF_DEPTH) begin
				if (int'(c.val) > COEF_TOP) begin
					coef_mirror[c.idx] = coef_t'(COEF_TOP);
				end else if (int'(c.val) < COEF_BOTTOM) begin
					coef_mirror[c.idx] = coef_t'(COEF_BOTTOM);
				end else begin
					coef_mirror[c.idx] = c.val[COEF_W-1:0];
				end
			end
			return 1'b0;
		end
		if (c.op == OP_STATE) begin
			if (int'(c.idx) < N_STATES) begin
				state_mirror[c.idx[XW-1:0]] = c.val;
			end
			return 1'b0;
		end
		if (c.op != OP_STEP) begin
			return 1'b0;
		end
		u_vec[0] = c.ua;
		u_vec[1] = c.ub;
		for (int i = 0; i < N_OUTPUTS && i < 2; i++) begin
			sum = 0;
			for (int k = 0; k < N_STATES; k++) begin
				sum += longint'(coef_mirror[C_BASE + i * N_STATES + k]) *
					longint'(state_mirror[k]);
			end
			y[i] = round_clip(sum, clipped);
		end
		r.ya = y[0];
		r.yb = y[1];
		r.x0 = state_mirror[0];
		r.x1 = state_mirror[1];
		r.x2 = state_mirror[2];
		r.x3 = state_mirror[3];
		for (int i = 0; i < N_STATES; i++) begin
			sum = 0;
			for (int k = 0; k < N_STATES; k++) begin
				sum += longint'(coef_mirror[A_BASE + i * N_STATES + k]) *
					longint'(state_mirror[k]);
			end
			for (int k = 0; k < N_INPUTS && k < 2; k++) begin
				sum += longint'(coef_mirror[B_BASE + i * N_INPUTS + k]) *
					longint'(u_vec[k]);
			end
			x_next[i] = round_clip(sum, clipped);
		end
		for (int i = 0; i < N_STATES; i++) begin
			state_mirror[i] = x_next[i];
		end
		r.sat = clipped;
		return 1'b1;
	endfunction

	// mostly short gaps, a few long ones, and calm stretches with none
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 70);
	endfunction

	function automatic sig_t rand_sig(input int span);
		if (span <= 0) begin
			return sig_t'($urandom);
		end
		return sig_t'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	task automatic add_cmd(input logic [1:0] op, input int idx, input sig_t val,
			input sig_t ua, input sig_t ub);
		cmd_t c;
		c.op = op;
		c.idx = idx[4:0];
		c.val = val;
		c.ua = ua;
		c.ub = ub;
		pending.push_back(c);
		if (op == OP_COEF || op == OP_STEP || (op == OP_STATE && idx < N_STATES)) begin
			real_items++;
		end
	endtask

	task automatic add_episode();
		int kind;
		int n;
		int idx;
		int span;
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			n = ($urandom_range(0, 9) < 3) ? COEF_DEPTH : $urandom_range(1, COEF_DEPTH);
			for (int j = 0; j < n; j++) begin
				idx = (n == COEF_DEPTH) ? j : $urandom_range(0, COEF_DEPTH - 1);
				span = (idx < B_BASE) ? 4096 : (idx < C_BASE) ? 16384 : COEF_TOP;
				if ($urandom_range(0, 9) == 0) span = 0;
				add_cmd(OP_COEF, idx, rand_sig(span), sig_t'($urandom), sig_t'($urandom));
			end
			if ($urandom_range(0, 1)) begin
				n = $urandom_range(1, N_STATES);
				for (int j = 0; j < n; j++) begin
					span = ($urandom_range(0, 9) == 0) ? 0 : (1 << 16);
					add_cmd(OP_STATE, $urandom_range(0, N_STATES - 1), rand_sig(span),
						sig_t'($urandom), sig_t'($urandom));
				end
			end
			n = $urandom_range(2, 10);
			for (int j = 0; j < n; j++) begin
				span = ($urandom_range(0, 99) < 15) ? 0 : (1 << 14);
				add_cmd(OP_STEP, $urandom_range(0, 31), sig_t'($urandom),
					rand_sig(span), rand_sig(span));
			end
		end else begin
			n = $urandom_range(3, 10);
			for (int j = 0; j < n; j++) begin
				add_cmd(logic'($urandom_range(0, 3)) ? 2'($urandom_range(0, 3)) : OP_NONE,
					$urandom_range(0, 31), sig_t'($urandom), sig_t'($urandom),
					sig_t'($urandom));
			end
		end
	endtask

	task automatic compare_field(input string name, input sig_t got, input sig_t wanted);
		if (got !== wanted) begin
			report_error($sformatf("result %0d %s: got %0d expected %0d",
				results_seen, name, got, wanted));
		end
	endtask

	// driver: one item per transfer, random gaps between items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= '0;
			index <= '0;
			value <= '0;
			input_a <= '0;
			input_b <= '0;
		end else begin
			if (in_valid && in_ready) begin
				if (plant_apply(cur_cmd, new_result)) begin
					step_results_due.push_back(new_result);
				end
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending.size() > 0) begin
					cur_cmd = pending.pop_front();
					opcode <= cur_cmd.op;
					index <= cur_cmd.idx;
					value <= cur_cmd.val;
					input_a <= cur_cmd.ua;
					input_b <= cur_cmd.ub;
					in_valid <= 1'b1;
					send_gap = pick_gap(send_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result transfer, random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (step_results_due.size() == 0) begin
					report_error($sformatf("result %0d arrived with no step pending",
						results_seen));
				end else begin
					want = step_results_due.pop_front();
					compare_field("out_a", out_a, want.ya);
					compare_field("out_b", out_b, want.yb);
					compare_field("state_e0", state_e0, want.x0);
					compare_field("state_e1", state_e1, want.x1);
					compare_field("state_e2", state_e2, want.x2);
					compare_field("state_e3", state_e3, want.x3);
					compare_field("saturated", sig_t'(saturated), sig_t'(want.sat));
				end
				results_seen++;
			end
			if (take_stall > 0) begin
				take_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				take_stall = pick_gap(take_calm);
			end
		end
	end

	initial begin
		foreach (coef_mirror[i]) coef_mirror[i] = '0;
		foreach (state_mirror[i]) state_mirror[i] = '0;

		// zero store after reset, ignored opcode, extremes and saturation
		add_cmd(OP_STEP, 0, '0, '0, '0);
		add_cmd(OP_NONE, 31, sig_t'(-1), sig_t'(-1), sig_t'(-1));
		add_cmd(OP_COEF, 0, SIG_MAX, '0, '0);
		add_cmd(OP_COEF, 5, SIG_MIN, '0, '0);
		add_cmd(OP_COEF, 10, sig_t'(16384), '0, '0);
		add_cmd(OP_COEF, 15, sig_t'(-16384), '0, '0);
		add_cmd(OP_COEF, 16, sig_t'(16384), '0, '0);
		add_cmd(OP_COEF, 19, sig_t'(COEF_BOTTOM), '0, '0);
		add_cmd(OP_COEF, 23, sig_t'(COEF_TOP), '0, '0);
		add_cmd(OP_COEF, 27, sig_t'(-20000), '0, '0);
		add_cmd(OP_COEF, 31, sig_t'(32768), '0, '0);
		add_cmd(OP_STATE, 0, SIG_MAX, '0, '0);
		add_cmd(OP_STATE, 1, sig_t'(4096), '0, '0);
		add_cmd(OP_STATE, 3, SIG_MIN, '0, '0);
		add_cmd(OP_STATE, 4, sig_t'(77), '0, '0);
		add_cmd(OP_STATE, 31, sig_t'(-5), '0, '0);
		add_cmd(OP_STEP, 0, '0, SIG_MAX, SIG_MIN);
		add_cmd(OP_STEP, 0, '0, sig_t'(-1), sig_t'(1));
		// round half up: +0.5 lsb goes up, -0.5 lsb goes to zero
		add_cmd(OP_COEF, 24, sig_t'(1), '0, '0);
		add_cmd(OP_COEF, 28, sig_t'(-1), '0, '0);
		add_cmd(OP_STATE, 0, sig_t'(8192), '0, '0);
		add_cmd(OP_STATE, 1, '0, '0, '0);
		add_cmd(OP_STATE, 2, '0, '0, '0);
		add_cmd(OP_STATE, 3, '0, '0, '0);
		add_cmd(OP_STEP, 0, '0, '0, '0);

		real_items = 0;
		while (real_items < ITEM_TARGET) begin
			add_episode();
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending.size() > 0 || in_valid) @(posedge clk);
		while (step_results_due.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/dss_pkg.sv
rtl/dss_coef_store.sv
rtl/dss_mac.sv
rtl/discrete_state_space_step_unit.sv
sim/discrete_state_space_step_unit_tb.sv
